[rtl/jsc_pkg.sv]
// Package with the shared types, phase codes and byte classes of the JSON checker.
`timescale 1ns / 1ps

package jsc_pkg;

   localparam logic [3:0] PH_VALUE   = 4'd0;
   localparam logic [3:0] PH_STRING  = 4'd1;
   localparam logic [3:0] PH_ESCAPE  = 4'd2;
   localparam logic [3:0] PH_HEX     = 4'd3;
   localparam logic [3:0] PH_INT     = 4'd4;
   localparam logic [3:0] PH_FRAC    = 4'd5;
   localparam logic [3:0] PH_EXP     = 4'd6;
   localparam logic [3:0] PH_LITERAL = 4'd7;
   localparam logic [3:0] PH_OBJ     = 4'd8;
   localparam logic [3:0] PH_COLON   = 4'd9;
   localparam logic [3:0] PH_ARR     = 4'd10;
   localparam logic [3:0] PH_DONE    = 4'd11;

   localparam logic [1:0] MS_KEY    = 2'd0;
   localparam logic [1:0] MS_IN_KEY = 2'd1;
   localparam logic [1:0] MS_VALUE  = 2'd2;

   localparam logic KIND_ARRAY  = 1'b0;
   localparam logic KIND_OBJECT = 1'b1;

   // literal positions: true at 0, false at 4, null at 9, end at 13
   localparam logic [3:0] LIT_TRUE  = 4'd1;
   localparam logic [3:0] LIT_FALSE = 4'd5;
   localparam logic [3:0] LIT_NULL  = 4'd10;

   typedef struct packed {
      logic [3:0] phase;
      logic [1:0] member;
      logic [1:0] hex_count;
      logic [3:0] lit_pos;
      logic       finished;
      logic       failed;
      logic       overflowed;
   } ctl_type;

   typedef struct packed {
      ctl_type ctl;
      logic    push;
      logic    kind;
      logic    pop;
      logic    redo;
   } step_type;

   function automatic logic is_ws(logic [7:0] b);
      return b == 8'h20 || b == 8'h09 || b == 8'h0A || b == 8'h0D;
   endfunction

   function automatic logic is_digit(logic [7:0] b);
      return b >= 8'h30 && b <= 8'h39;
   endfunction

   function automatic logic is_hex(logic [7:0] b);
      return is_digit(b) || (b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46);
   endfunction

   function automatic logic [7:0] lit_char(logic [3:0] pos);
      logic [7:0] c;
      case (pos)
         4'd0:    c = 8'h74;
         4'd1:    c = 8'h72;
         4'd2:    c = 8'h75;
         4'd3:    c = 8'h65;
         4'd4:    c = 8'h66;
         4'd5:    c = 8'h61;
         4'd6:    c = 8'h6C;
         4'd7:    c = 8'h73;
         4'd8:    c = 8'h65;
         4'd9:    c = 8'h6E;
         4'd10:   c = 8'h75;
         4'd11:   c = 8'h6C;
         4'd12:   c = 8'h6C;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

[rtl/jsc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module jsc_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 32
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/json_syntax_checker.sv]
// Top level of the streaming JSON syntax checker.
`timescale 1ns / 1ps

// Streaming JSON syntax checker. Feed the text one byte per beat on req_, with
// req_tlast on the final byte; one verdict beat comes out on rsp_ for that byte
// (is_valid, too_deep) and the checker is then back in its reset state for the
// next text. A byte, including one that ends a number and is then re-examined
// in the enclosing context, is resolved in one state update, so a byte can be
// taken every cycle while the output is free. The only back-pressure is
// a verdict beat still waiting in the output register. Open objects and arrays
// sit on a stack of MAX_DEPTH entries in a RAM; the top entry and the one below
// it are held in registers so a close is resolved without waiting for a read.
// No clearing pass is needed after reset. Opening a container when MAX_DEPTH
// are open fails the text and raises too_deep.
module json_syntax_checker #(
   parameter int MAX_DEPTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] text_byte
   input  logic       req_tlast,   // last_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [0] is_valid, [1] too_deep, [7:2] zero
);
   import jsc_pkg::*;

   localparam int AW = MAX_DEPTH > 1 ? $clog2(MAX_DEPTH) : 1;
   localparam int LW = $clog2(MAX_DEPTH + 1);

   ctl_type         ctl_ff, ctl_in;
   logic [LW-1:0]   nest_ff, nest_in;
   logic            top_ff, top_in;
   logic            below;
   logic            rsp_tvalid_ff;
   logic [1:0]      rsp_data_ff;
   logic            accept;
   step_type        pass1, fin;
   logic            full, lvl_zero, lvl_one;
   logic            num_open, verdict;

   // Close out a value: finish at top level, else back to the container.
   function automatic ctl_type value_done(ctl_type c, logic lz, logic kind);
      ctl_type r;
      r = c;
      if (lz) begin
         r.finished = 1'b1;
         r.phase = PH_DONE;
      end else if (kind == KIND_OBJECT) begin
         r.member = MS_KEY;
         r.phase = PH_OBJ;
      end else begin
         r.phase = PH_ARR;
      end
      return r;
   endfunction

   function automatic step_type start_value(step_type s, logic [7:0] b, logic is_full);
      step_type r;
      r = s;
      if (b == 8'h22) begin
         r.ctl.phase = PH_STRING;
      end else if (b == 8'h2D || is_digit(b)) begin
         r.ctl.phase = PH_INT;
      end else if (b == 8'h7B || b == 8'h5B) begin
         if (is_full) begin
            r.ctl.overflowed = 1'b1;
            r.ctl.failed = 1'b1;
         end else begin
            r.push = 1'b1;
            r.kind = (b == 8'h7B) ? KIND_OBJECT : KIND_ARRAY;
            if (b == 8'h7B) begin
               r.ctl.member = MS_KEY;
               r.ctl.phase = PH_OBJ;
            end else begin
               r.ctl.phase = PH_ARR;
            end
         end
      end else if (b == 8'h74) begin
         r.ctl.lit_pos = LIT_TRUE;
         r.ctl.phase = PH_LITERAL;
      end else if (b == 8'h66) begin
         r.ctl.lit_pos = LIT_FALSE;
         r.ctl.phase = PH_LITERAL;
      end else if (b == 8'h6E) begin
         r.ctl.lit_pos = LIT_NULL;
         r.ctl.phase = PH_LITERAL;
      end else begin
         r.ctl.failed = 1'b1;
      end
      return r;
   endfunction

   // One examination of a byte in the current phase.
   function automatic step_type handle(ctl_type c, logic [7:0] b, logic top, logic lz,
                                       logic l1, logic blw, logic is_full);
      step_type   r;
      logic [3:0] nxt;
      r.ctl = c;
      r.push = 1'b0;
      r.kind = KIND_ARRAY;
      r.pop = 1'b0;
      r.redo = 1'b0;
      nxt = c.lit_pos + 4'd1;
      unique case (c.phase)
         PH_VALUE: begin
            if (!is_ws(b)) r = start_value(r, b, is_full);
         end
         PH_STRING: begin
            if (b == 8'h5C) begin
               r.ctl.phase = PH_ESCAPE;
            end else if (b == 8'h22) begin
               if (!lz && top == KIND_OBJECT && c.member == MS_IN_KEY)
                  r.ctl.phase = PH_COLON;
               else
                  r.ctl = value_done(c, lz, top);
            end
         end
         PH_ESCAPE: begin
            if (b == 8'h22 || b == 8'h5C || b == 8'h2F || b == 8'h62 || b == 8'h66 ||
                b == 8'h6E || b == 8'h72 || b == 8'h74) begin
               r.ctl.phase = PH_STRING;
            end else if (b == 8'h75) begin
               r.ctl.hex_count = 2'd0;
               r.ctl.phase = PH_HEX;
            end else begin
               r.ctl.failed = 1'b1;
            end
         end
         PH_HEX: begin
            if (!is_hex(b)) begin
               r.ctl.failed = 1'b1;
            end else if (c.hex_count == 2'd3) begin
               r.ctl.hex_count = 2'd0;
               r.ctl.phase = PH_STRING;
            end else begin
               r.ctl.hex_count = c.hex_count + 2'd1;
            end
         end
         PH_INT, PH_FRAC, PH_EXP: begin
            if (is_digit(b)) begin
               r.redo = 1'b0;
            end else if (c.phase == PH_EXP && (b == 8'h2B || b == 8'h2D)) begin
               r.redo = 1'b0;
            end else if (c.phase == PH_INT && b == 8'h2E) begin
               r.ctl.phase = PH_FRAC;
            end else if (c.phase != PH_EXP && (b == 8'h65 || b == 8'h45)) begin
               r.ctl.phase = PH_EXP;
            end else begin
               // number ends here: hand the byte to the enclosing context
               r.ctl = value_done(c, lz, top);
               r.redo = 1'b1;
            end
         end
         PH_LITERAL: begin
            if (c.lit_pos < 4'd13 && b == lit_char(c.lit_pos)) begin
               r.ctl.lit_pos = nxt;
               if (nxt == 4'd4 || nxt == 4'd9 || nxt == 4'd13) begin
                  r.ctl.lit_pos = 4'd0;
                  r.ctl = value_done(r.ctl, lz, top);
               end
            end else begin
               r.ctl.failed = 1'b1;
            end
         end
         PH_OBJ: begin
            if (is_ws(b) || b == 8'h2C) begin
               r.redo = 1'b0;
            end else if (b == 8'h7D) begin
               r.pop = 1'b1;
               r.ctl = value_done(c, l1, blw);
            end else if (b == 8'h22) begin
               r.ctl.member = MS_IN_KEY;
               r.ctl.phase = PH_STRING;
            end else begin
               r.ctl.failed = 1'b1;
            end
         end
         PH_COLON: begin
            if (b == 8'h3A) begin
               r.ctl.member = MS_VALUE;
               r.ctl.phase = PH_VALUE;
            end else begin
               r.ctl.failed = 1'b1;
            end
         end
         PH_ARR: begin
            if (is_ws(b) || b == 8'h2C) begin
               r.redo = 1'b0;
            end else if (b == 8'h5D) begin
               r.pop = 1'b1;
               r.ctl = value_done(c, l1, blw);
            end else begin
               r = start_value(r, b, is_full);
            end
         end
         default: begin
            r.redo = 1'b0;
         end
      endcase
      return r;
   endfunction

   // take a byte whenever the verdict register is free or draining
   assign req_tready = !rsp_tvalid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign full     = nest_ff == LW'(MAX_DEPTH);
   assign lvl_zero = nest_ff == '0;
   assign lvl_one  = nest_ff == LW'(1);

   always_comb begin
      pass1 = handle(ctl_ff, req_tdata, top_ff, lvl_zero, lvl_one, below, full);
      if (ctl_ff.failed || ctl_ff.finished) begin
         fin.ctl  = ctl_ff;
         fin.push = 1'b0;
         fin.kind = KIND_ARRAY;
         fin.pop  = 1'b0;
         fin.redo = 1'b0;
      end else if (pass1.redo && !pass1.ctl.failed && !pass1.ctl.finished) begin
         fin = handle(pass1.ctl, req_tdata, top_ff, lvl_zero, lvl_one, below, full);
      end else begin
         fin = pass1;
      end
   end

   // a number still open at the end of the text completes it at top level
   assign num_open = !fin.ctl.failed && !fin.ctl.finished &&
                     (fin.ctl.phase == PH_INT || fin.ctl.phase == PH_FRAC ||
                      fin.ctl.phase == PH_EXP);
   assign verdict  = !fin.ctl.failed && (fin.ctl.finished || (num_open && lvl_zero));

   always_comb begin
      ctl_in  = ctl_ff;
      nest_in = nest_ff;
      top_in  = top_ff;
      if (accept) begin
         if (req_tlast) begin
            // drop back to the reset state for the next text
            ctl_in  = '0;
            ctl_in.phase  = PH_VALUE;
            ctl_in.member = MS_KEY;
            nest_in = '0;
         end else begin
            ctl_in = fin.ctl;
            if (fin.push) begin
               nest_in = nest_ff + LW'(1);
               top_in  = fin.kind;
            end else if (fin.pop) begin
               nest_in = nest_ff - LW'(1);
               top_in  = below;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff        <= '0;
         ctl_ff.phase  <= PH_VALUE;
         ctl_ff.member <= MS_KEY;
         nest_ff       <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         ctl_ff  <= ctl_in;
         nest_ff <= nest_in;
         if (accept && req_tlast) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      top_ff <= top_in;
      if (accept && req_tlast) begin
         rsp_data_ff <= {fin.ctl.overflowed, verdict};
      end
   end

   // Stack RAM: entry i holds the kind of the container opened at level i.
   // The read port always fetches the entry below the next top.
   logic [LW-1:0] rd_level;
   assign rd_level = nest_in - LW'(2);

   jsc_ram #(
      .WIDTH (1),
      .DEPTH (MAX_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (accept && !req_tlast && fin.push),
      .wr_addr (nest_ff[AW-1:0]),
      .wr_data (fin.kind),
      .rd_addr (rd_level[AW-1:0]),
      .rd_data (below)
   );

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {6'd0, rsp_data_ff};

`ifndef SYNTHESIS
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      nest_ff <= LW'(MAX_DEPTH))
      else $error("nesting level beyond stack depth");

   a_overflow_fails: assert property (@(posedge clock) disable iff (reset)
      ctl_ff.overflowed |-> ctl_ff.failed)
      else $error("overflow without failure");

   a_deep_invalid: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && rsp_data_ff[1]) |-> !rsp_data_ff[0])
      else $error("too_deep verdict marked valid");

   a_last_resets: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tlast) |=> (nest_ff == '0 && ctl_ff.phase == PH_VALUE))
      else $error("state not cleared after last byte");
`endif

endmodule
